// File: rtl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and helpers for the triangle shape function block
// Holds the controller/datapath command and status structs, the state and
// multiplier operation codes, and the natural derivative table.
// ----------------------------------------------------------------------------
`default_nettype none

package tsf_pkg;

  // default build values
  localparam int DEF_MAX_NODES = 6;
  localparam int DEF_FRAC_BITS = 16;

  // field widths fixed by the interface
  localparam int NODE_W  = 3;
  localparam int COORD_W = 32;
  localparam int NAT_W   = 18;
  localparam int SHAPE_W = 18;
  localparam int DER_W   = 32;
  localparam int DET_W   = 64;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // element kinds
  localparam logic KIND_LINEAR = 1'b0;
  localparam logic KIND_QUAD   = 1'b1;

  // last node number per element kind
  localparam logic [NODE_W-1:0] LAST_NODE_LIN  = 3'd2;
  localparam logic [NODE_W-1:0] LAST_NODE_QUAD = 3'd5;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JAC,
    ST_GMAKE,
    ST_DET,
    ST_NODE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // shared multiplier operations
  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_J_D0X,
    MOP_J_D0Y,
    MOP_J_D1X,
    MOP_J_D1Y,
    MOP_DET_A,
    MOP_DET_B,
    MOP_SHAPE,
    MOP_NX_A,
    MOP_NX_B,
    MOP_NY_A,
    MOP_NY_B
  } mop_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              capture;
    mop_t              mop;
    logic [NODE_W-1:0] node;
    logic              make_g;
    logic              div_start;
    logic              emit;
    logic              last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic kind;
  } stat_t;

  // natural derivatives of one node
  typedef struct packed {
    logic signed [31:0] d0;
    logic signed [31:0] d1;
  } deriv_t;

  // derivatives along xi and eta of the shape function of a node
  function automatic deriv_t nat_deriv(input logic kind,
                                       input logic [NODE_W-1:0] node,
                                       input logic signed [31:0] xi,
                                       input logic signed [31:0] eta,
                                       input logic signed [31:0] l3,
                                       input logic signed [31:0] one);
    deriv_t r;
    r.d0 = '0;
    r.d1 = '0;
    if (kind == KIND_QUAD) begin
      unique case (node)
        3'd0: begin r.d0 = (xi <<< 2) - one; end
        3'd1: begin r.d1 = (eta <<< 2) - one; end
        3'd2: begin
          r.d0 = one - (l3 <<< 2);
          r.d1 = one - (l3 <<< 2);
        end
        3'd3: begin
          r.d0 = eta <<< 2;
          r.d1 = xi <<< 2;
        end
        3'd4: begin
          r.d0 = -(eta <<< 2);
          r.d1 = (one - xi - (eta <<< 1)) <<< 2;
        end
        3'd5: begin
          r.d0 = (one - (xi <<< 1) - eta) <<< 2;
          r.d1 = -(xi <<< 2);
        end
        default: ;
      endcase
    end else begin
      unique case (node)
        3'd0: begin r.d0 = one; end
        3'd1: begin r.d1 = one; end
        3'd2: begin
          r.d0 = -one;
          r.d1 = -one;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tsf_div.sv
// ----------------------------------------------------------------------------
// tsf_div: radix-2 restoring divider with saturation
// Computes trunc(num * 2^SH / den) saturated to signed 32 bits, one quotient
// bit per cycle after an overflow check.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_div #(
  parameter int SH = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire  signed [63:0] num,
  input  wire  signed [63:0] den,
  output logic               done,
  output logic signed [31:0] quot
);
  import tsf_pkg::*;

  localparam int NW = 64 + SH;
  localparam int QB = 33;
  localparam int HW = NW - QB;

  logic        busy_r;
  logic        init_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r;
  logic [QB-1:0] low_r;
  logic [QB-1:0] q_r;
  logic [63:0] d_r;
  logic        neg_r;
  logic        ovf_r;

  logic [63:0] n_abs;
  logic [63:0] d_abs;
  logic [NW-1:0] n_sh;
  logic [64:0] trial;
  logic        fits;

  // magnitudes and the shifted numerator
  always_comb begin
    n_abs = num[63] ? 64'(-num) : 64'(num);
    d_abs = den[63] ? 64'(-den) : 64'(den);
    n_sh  = {n_abs, {SH{1'b0}}};
    trial = {rem_r, low_r[QB-1]};
    fits  = trial >= {1'b0, d_r};
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      init_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        init_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && init_r) begin
        init_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(QB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 64'(n_sh[NW-1:QB]);
      low_r <= n_sh[QB-1:0];
      d_r   <= d_abs;
      neg_r <= num[63] ^ den[63];
      q_r   <= '0;
    end else if (busy_r && init_r) begin
      ovf_r <= {{(64-HW){1'b0}}, rem_r[HW-1:0]} >= d_r;
    end else if (busy_r) begin
      low_r <= {low_r[QB-2:0], 1'b0};
      if (fits) begin
        rem_r <= 64'(trial - {1'b0, d_r});
        q_r   <= {q_r[QB-2:0], 1'b1};
      end else begin
        rem_r <= trial[63:0];
        q_r   <= {q_r[QB-2:0], 1'b0};
      end
    end
  end

  // sign and saturation
  always_comb begin
    if (neg_r) begin
      if (ovf_r || q_r > 33'h080000000) quot = 32'sh80000000;
      else                              quot = -$signed(q_r[31:0]);
    end else begin
      if (ovf_r || q_r > 33'h07fffffff) quot = 32'sh7fffffff;
      else                              quot = $signed(q_r[31:0]);
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

// File: rtl/tsf_dp.sv
// ----------------------------------------------------------------------------
// tsf_dp: datapath of the triangle shape function block
// Node store, one shared 32x32 multiplier with accumulators, Jacobian and
// determinant registers, two dividers and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_dp #(
  parameter int MAX_NODES = 6,
  parameter int FRAC_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  tsf_pkg::cmd_t       cmd,
  output tsf_pkg::stat_t      stat,
  input  wire                 cfg_we,
  input  wire                 cfg_wdata,
  input  wire  [2:0]          in_node_index,
  input  wire  signed [31:0]  in_coord_x,
  input  wire  signed [31:0]  in_coord_y,
  input  wire  signed [17:0]  in_xi,
  input  wire  signed [17:0]  in_eta,
  output logic                out_valid,
  output logic [2:0]          out_result_node,
  output logic signed [17:0]  out_shape_value,
  output logic signed [31:0]  out_dshape_dx,
  output logic signed [31:0]  out_dshape_dy,
  output logic signed [63:0]  out_jacobian_det,
  output logic                out_singular,
  output logic                out_last
);
  import tsf_pkg::*;

  localparam int IDXW = $clog2(MAX_NODES);
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // node store, undefined until loaded
  logic signed [31:0] x_mem [MAX_NODES];
  logic signed [31:0] y_mem [MAX_NODES];

  logic               kind_r;
  logic signed [17:0] xi_r;
  logic signed [17:0] eta_r;
  mop_t               mop_d_r;
  logic signed [63:0] p_r;
  logic signed [63:0] a0_r, a1_r, b0_r, b1_r;
  logic signed [31:0] g00_r, g01_r, g10_r, g11_r;
  logic signed [63:0] det_r;
  logic signed [63:0] sv_r;
  logic signed [63:0] nx_r, ny_r;
  logic               out_valid_r;

  logic signed [31:0] xi_w, eta_w, l3;
  logic               node_ok;
  logic signed [31:0] cx, cy;
  deriv_t             dv;
  logic signed [31:0] sa, sb;
  logic               sq_form;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] sv_post;
  logic signed [31:0] gr00, gr01, gr10, gr11;
  logic signed [63:0] sv_rnd;
  logic signed [17:0] shape_sat;
  logic               det_zero;
  logic               done_x, done_y;
  logic signed [31:0] qx, qy;

  // round half up to Q16.16 and saturate to 32 bits
  function automatic logic signed [31:0] rnd_sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + HALF) >>> FRAC_BITS;
    if (r > 64'sh000000007fffffff)      return 32'sh7fffffff;
    else if (r < -64'sh0000000080000000) return 32'sh80000000;
    else                                 return r[31:0];
  endfunction

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)      kind_r <= KIND_LINEAR;
    else if (cfg_we) kind_r <= cfg_wdata;
  end

  // node store write
  always_ff @(posedge clk) begin
    if (cmd.load && ({29'd0, in_node_index} < 32'(MAX_NODES))) begin
      x_mem[in_node_index[IDXW-1:0]] <= in_coord_x;
      y_mem[in_node_index[IDXW-1:0]] <= in_coord_y;
    end
  end

  // natural point and the third area coordinate
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xi_r  <= in_xi;
      eta_r <= in_eta;
    end
  end

  always_comb begin
    xi_w  = 32'(xi_r);
    eta_w = 32'(eta_r);
    l3    = ONE - xi_w - eta_w;
    node_ok = {29'd0, cmd.node} < 32'(MAX_NODES);
    cx = node_ok ? x_mem[cmd.node[IDXW-1:0]] : '0;
    cy = node_ok ? y_mem[cmd.node[IDXW-1:0]] : '0;
    dv = nat_deriv(kind_r, cmd.node, xi_w, eta_w, l3, ONE);
  end

  // shape product operands for the current node
  always_comb begin
    sa = xi_w;
    sb = ONE;
    sq_form = 1'b0;
    if (kind_r == KIND_QUAD) begin
      unique case (cmd.node)
        3'd0:    begin sa = xi_w;  sb = xi_w;  sq_form = 1'b1; end
        3'd1:    begin sa = eta_w; sb = eta_w; sq_form = 1'b1; end
        3'd2:    begin sa = l3;    sb = l3;    sq_form = 1'b1; end
        3'd3:    begin sa = xi_w;  sb = eta_w; end
        3'd4:    begin sa = eta_w; sb = l3;    end
        3'd5:    begin sa = xi_w;  sb = l3;    end
        default: begin sa = '0;    sb = '0;    end
      endcase
    end else begin
      unique case (cmd.node)
        3'd0:    sa = xi_w;
        3'd1:    sa = eta_w;
        3'd2:    sa = l3;
        default: sa = '0;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.mop)
      MOP_J_D0X: begin mul_a = dv.d0; mul_b = cx;    end
      MOP_J_D0Y: begin mul_a = dv.d0; mul_b = cy;    end
      MOP_J_D1X: begin mul_a = dv.d1; mul_b = cx;    end
      MOP_J_D1Y: begin mul_a = dv.d1; mul_b = cy;    end
      MOP_DET_A: begin mul_a = g00_r; mul_b = g11_r; end
      MOP_DET_B: begin mul_a = g01_r; mul_b = g10_r; end
      MOP_SHAPE: begin mul_a = sa;    mul_b = sb;    end
      MOP_NX_A:  begin mul_a = g11_r; mul_b = dv.d0; end
      MOP_NX_B:  begin mul_a = g01_r; mul_b = dv.d1; end
      MOP_NY_A:  begin mul_a = g00_r; mul_b = dv.d1; end
      MOP_NY_B:  begin mul_a = g10_r; mul_b = dv.d0; end
      default:   begin mul_a = '0;    mul_b = '0;    end
    endcase
    prod = mul_a * mul_b;
  end

  // shape value from its product
  always_comb begin
    if (kind_r == KIND_QUAD) begin
      if (sq_form) sv_post = (p_r <<< 1) - (64'(sa) <<< FRAC_BITS);
      else         sv_post = p_r <<< 2;
    end else begin
      sv_post = p_r;
    end
  end

  // product register and operation tag
  always_ff @(posedge clk) begin
    if (!rst_n) mop_d_r <= MOP_NONE;
    else        mop_d_r <= cmd.mop;
  end

  always_ff @(posedge clk) begin
    p_r <= prod;
  end

  // accumulate products into their destinations
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a0_r <= '0;
      a1_r <= '0;
      b0_r <= '0;
      b1_r <= '0;
    end else begin
      unique case (mop_d_r)
        MOP_J_D0X: a0_r  <= a0_r + p_r;
        MOP_J_D0Y: a1_r  <= a1_r + p_r;
        MOP_J_D1X: b0_r  <= b0_r + p_r;
        MOP_J_D1Y: b1_r  <= b1_r + p_r;
        MOP_DET_A: det_r <= p_r;
        MOP_DET_B: det_r <= det_r - p_r;
        MOP_SHAPE: sv_r  <= sv_post;
        MOP_NX_A:  nx_r  <= p_r;
        MOP_NX_B:  nx_r  <= nx_r - p_r;
        MOP_NY_A:  ny_r  <= p_r;
        MOP_NY_B:  ny_r  <= ny_r - p_r;
        default: ;
      endcase
    end
  end

  // Jacobian entries
  always_comb begin
    gr00 = rnd_sat32(a0_r);
    gr01 = rnd_sat32(a1_r);
    gr10 = rnd_sat32(b0_r);
    gr11 = rnd_sat32(b1_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.make_g) begin
      g00_r <= gr00;
      g01_r <= gr01;
      g10_r <= gr10;
      g11_r <= gr11;
    end
  end

  // adjugate numerators over the determinant
  tsf_div #(.SH(32 - FRAC_BITS)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (nx_r),
    .den   (det_r),
    .done  (done_x),
    .quot  (qx)
  );

  tsf_div #(.SH(32 - FRAC_BITS)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (ny_r),
    .den   (det_r),
    .done  (done_y),
    .quot  (qy)
  );

  // shape value rounding and saturation
  always_comb begin
    sv_rnd   = (sv_r + HALF) >>> FRAC_BITS;
    det_zero = (det_r == 64'sd0);
    if (sv_rnd > 64'sd131071)       shape_sat = 18'sh1ffff;
    else if (sv_rnd < -64'sd131072) shape_sat = 18'sh20000;
    else                            shape_sat = sv_rnd[17:0];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_result_node  <= cmd.node;
      out_shape_value  <= shape_sat;
      out_dshape_dx    <= det_zero ? 32'sd0 : qx;
      out_dshape_dy    <= det_zero ? 32'sd0 : qy;
      out_jacobian_det <= det_r;
      out_singular     <= det_zero;
      out_last         <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.div_done = done_x & done_y;
  assign stat.kind     = kind_r;

endmodule

`default_nettype wire

// File: rtl/tsf_ctrl.sv
// ----------------------------------------------------------------------------
// tsf_ctrl: sequencer of the triangle shape function block
// Steps the datapath through Jacobian accumulation, determinant, and per node
// shape product, adjugate numerators, division and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  input  wire            req_type,
  input  tsf_pkg::stat_t stat,
  output logic           busy,
  output tsf_pkg::cmd_t  cmd
);
  import tsf_pkg::*;

  state_t      state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [NODE_W-1:0] last_node;

  assign last_node = (stat.kind == KIND_QUAD) ? LAST_NODE_QUAD : LAST_NODE_LIN;
  assign busy      = (state_r != ST_IDLE);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      node_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      node_r  <= node_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 3'd1;
    node_nxt  = node_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        node_nxt = '0;
        if (start && req_type == REQ_EVAL) state_nxt = ST_JAC;
      end
      ST_JAC: begin
        if (step_r[1:0] == 2'd3) begin
          step_nxt = '0;
          if (node_r == last_node) begin
            node_nxt  = '0;
            state_nxt = ST_GMAKE;
          end else begin
            node_nxt = node_r + 3'd1;
          end
        end
      end
      ST_GMAKE: begin
        if (step_r[0]) begin
          step_nxt  = '0;
          state_nxt = ST_DET;
        end
      end
      ST_DET: begin
        if (step_r == 3'd2) begin
          step_nxt  = '0;
          state_nxt = ST_NODE;
        end
      end
      ST_NODE: begin
        if (step_r == 3'd6) begin
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        step_nxt = '0;
        if (stat.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        step_nxt = '0;
        if (node_r == last_node) begin
          state_nxt = ST_IDLE;
        end else begin
          node_nxt  = node_r + 3'd1;
          state_nxt = ST_NODE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    cmd.mop  = MOP_NONE;
    cmd.node = node_r;
    cmd.last = (node_r == last_node);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load    = start && (req_type == REQ_LOAD);
        cmd.capture = start && (req_type == REQ_EVAL);
      end
      ST_JAC: begin
        unique case (step_r[1:0])
          2'd0:    cmd.mop = MOP_J_D0X;
          2'd1:    cmd.mop = MOP_J_D0Y;
          2'd2:    cmd.mop = MOP_J_D1X;
          default: cmd.mop = MOP_J_D1Y;
        endcase
      end
      ST_GMAKE: cmd.make_g = step_r[0];
      ST_DET: begin
        if (step_r == 3'd0)      cmd.mop = MOP_DET_A;
        else if (step_r == 3'd1) cmd.mop = MOP_DET_B;
      end
      ST_NODE: begin
        unique case (step_r)
          3'd0:    cmd.mop = MOP_SHAPE;
          3'd1:    cmd.mop = MOP_NX_A;
          3'd2:    cmd.mop = MOP_NX_B;
          3'd3:    cmd.mop = MOP_NY_A;
          3'd4:    cmd.mop = MOP_NY_B;
          3'd6:    cmd.div_start = 1'b1;
          default: ;
        endcase
      end
      ST_EMIT: cmd.emit = 1'b1;
      default: ;
    endcase
  end

  // checks
  a_eval_enters_jac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && req_type == REQ_EVAL) |=> state_r == ST_JAC)
    else $error("evaluate request did not start the jacobian pass");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && cmd.last) |=> state_r == ST_IDLE)
    else $error("final node result did not end the evaluation");

  a_div_start_waits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == ST_DIV)
    else $error("divider start not followed by divide wait");

  a_node_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> node_r <= last_node)
    else $error("node counter past last node");

endmodule

`default_nettype wire

// File: rtl/triangle_shape_function_eval.sv
// ----------------------------------------------------------------------------
// triangle_shape_function_eval: linear and quadratic triangle shape functions
// Load node coordinates, then evaluate shape values, global derivatives and
// the Jacobian determinant at a natural point, one result per node.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load request
// stores one node. An evaluate request with N nodes (3 linear, 6 quadratic)
// first does the Jacobian and determinant work on one shared 32x32
// multiplier, then for each node the shape product, the adjugate numerators
// and the bit-serial division of those numerators by the determinant
// (33 quotient bits, x and y in parallel). Results appear one at a time
// with out_valid high for a single cycle and must be taken then, since
// there is no backpressure. The user must write element_kind through
// cfg_we/cfg_wdata only while the block is idle; the block itself does not
// enforce this.
`default_nettype none

module triangle_shape_function_eval
  import tsf_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire                in_req_type,
  input  wire  [2:0]         in_node_index,
  input  wire  signed [31:0] in_coord_x,
  input  wire  signed [31:0] in_coord_y,
  input  wire  signed [17:0] in_xi,
  input  wire  signed [17:0] in_eta,
  input  wire                cfg_we,
  input  wire                cfg_wdata,
  output logic               out_valid,
  output logic [2:0]         out_result_node,
  output logic signed [17:0] out_shape_value,
  output logic signed [31:0] out_dshape_dx,
  output logic signed [31:0] out_dshape_dy,
  output logic signed [63:0] out_jacobian_det,
  output logic               out_singular,
  output logic               out_last
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  tsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // arithmetic and storage
  tsf_dp #(
    .MAX_NODES (MAX_NODES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_node_index    (in_node_index),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_xi            (in_xi),
    .in_eta           (in_eta),
    .out_valid        (out_valid),
    .out_result_node  (out_result_node),
    .out_shape_value  (out_shape_value),
    .out_dshape_dx    (out_dshape_dx),
    .out_dshape_dy    (out_dshape_dy),
    .out_jacobian_det (out_jacobian_det),
    .out_singular     (out_singular),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
